// ----- sv/plit_pkg.sv -----
`default_nettype none
package plit_pkg;
   localparam int CoordWidth = 24;
   localparam int TagWidth   = 16;
   localparam int ScoreWidth = 32;
   localparam int RankWidth  = 6;

   localparam logic [1:0] CsrCameraX = 2'd0;
   localparam logic [1:0] CsrCameraY = 2'd1;
   localparam logic [1:0] CsrCameraZ = 2'd2;

   // controller to datapath
   typedef struct packed {
      logic load;       // capture the transaction and start the difference stage
      logic sq_step;    // one squaring step: an axis or the doubled range
      logic sqrt_init;
      logic sqrt_step;
      logic den_calc;   // (d+256)^2
      logic div_init;
      logic div_step;
      logic scan_init;
      logic scan_step;  // compare one table entry, shift it down if needed
      logic insert;
      logic emit_init;
      logic emit_step;
      logic frame_clear;
   } plit_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic sqrt_done;
      logic div_done;
      logic scan_done;
      logic emit_done;
   } plit_status_type;
endpackage
`default_nettype wire

// ----- sv/plit_datapath.sv -----
`default_nettype none
module plit_datapath #(
   parameter int MAX_KEPT = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire plit_pkg::plit_cmd_type cmd,
   output plit_pkg::plit_status_type  status,
   input  wire logic                  csr_write,
   input  wire logic [1:0]            csr_index,
   input  wire logic [23:0]           csr_data,
   input  wire logic [15:0]           req_light_tag,
   input  wire logic signed [23:0]    req_pos_x,
   input  wire logic signed [23:0]    req_pos_y,
   input  wire logic signed [23:0]    req_pos_z,
   input  wire logic [23:0]           req_light_range,
   input  wire logic [15:0]           req_intensity,
   output logic [15:0]                out_tag,
   output logic [31:0]                out_score,
   output logic [5:0]                 out_rank,
   output logic                       out_last
);
   import plit_pkg::*;

   localparam int IdxW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
   localparam int CntW = $clog2(MAX_KEPT + 1);

   // camera registers
   logic signed [23:0] cam_x_ff, cam_y_ff, cam_z_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         cam_x_ff <= '0;
         cam_y_ff <= '0;
         cam_z_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CsrCameraX: cam_x_ff <= csr_data;
            CsrCameraY: cam_y_ff <= csr_data;
            CsrCameraZ: cam_z_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // distance: absolute differences, squares, sum, range test
   logic [24:0] ax_ff, ay_ff, az_ff;
   logic [15:0] tag_ff, inten_ff;
   logic [24:0] rng2_ff;
   logic [51:0] sum_ff;
   logic [49:0] rsq_ff;
   logic [1:0]  sq_phase_ff;
   logic        out_of_range;
   logic signed [24:0] dxs, dys, dzs;
   logic [24:0] sq_op;
   logic [49:0] sq_res;

   assign dxs = 25'(req_pos_x) - 25'(cam_x_ff);
   assign dys = 25'(req_pos_y) - 25'(cam_y_ff);
   assign dzs = 25'(req_pos_z) - 25'(cam_z_ff);

   always_comb begin
      unique case (sq_phase_ff)
         2'd0: sq_op = ax_ff;
         2'd1: sq_op = ay_ff;
         2'd2: sq_op = az_ff;
         default: sq_op = rng2_ff;
      endcase
   end
   // one shared multiplier for the three squares and the doubled range
   assign sq_res = sq_op * sq_op;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ax_ff       <= dxs[24] ? 25'(-dxs) : 25'(dxs);
         ay_ff       <= dys[24] ? 25'(-dys) : 25'(dys);
         az_ff       <= dzs[24] ? 25'(-dzs) : 25'(dzs);
         rng2_ff     <= {req_light_range, 1'b0};
         tag_ff      <= req_light_tag;
         inten_ff    <= req_intensity;
         sum_ff      <= '0;
         sq_phase_ff <= '0;
      end else if (cmd.sq_step) begin
         if (sq_phase_ff == 2'd3) rsq_ff <= sq_res;
         else sum_ff <= sum_ff + 52'(sq_res);
         sq_phase_ff <= sq_phase_ff + 2'd1;
      end
   end
   assign out_of_range = sum_ff > 52'(rsq_ff);

   // bit-pair square root, one result bit per cycle
   logic [25:0] root_ff;
   logic [4:0]  sq_cnt_ff;
   logic [51:0] sum_sh_ff;
   logic [27:0] acc_ff;
   logic [27:0] tsub;
   logic [27:0] acc_sh;
   assign acc_sh = {acc_ff[25:0], sum_sh_ff[51:50]};
   assign tsub   = {root_ff, 2'b01};
   always_ff @(posedge clock) begin
      if (cmd.sqrt_init) begin
         sum_sh_ff <= sum_ff;
         acc_ff    <= '0;
         root_ff   <= '0;
         sq_cnt_ff <= '0;
      end else if (cmd.sqrt_step) begin
         sum_sh_ff <= {sum_sh_ff[49:0], 2'b00};
         if (acc_sh >= tsub) begin
            acc_ff  <= acc_sh - tsub;
            root_ff <= {root_ff[24:0], 1'b1};
         end else begin
            acc_ff  <= acc_sh;
            root_ff <= {root_ff[24:0], 1'b0};
         end
         sq_cnt_ff <= sq_cnt_ff + 5'd1;
      end
   end

   // denominator and restoring division, one quotient bit per cycle
   logic [53:0] den_ff;
   logic [26:0] den_root;
   assign den_root = 27'(root_ff) + 27'd256;
   logic [47:0] dividend_ff;
   logic [54:0] prem_ff;
   logic [47:0] quo_ff;
   logic [5:0]  dv_cnt_ff;
   logic [54:0] prem_sh;
   assign prem_sh = {prem_ff[53:0], dividend_ff[47]};
   always_ff @(posedge clock) begin
      if (cmd.den_calc) begin
         den_ff <= den_root * den_root;
      end
      if (cmd.div_init) begin
         dividend_ff <= {inten_ff, 32'd0};
         prem_ff     <= '0;
         quo_ff      <= '0;
         dv_cnt_ff   <= '0;
      end else if (cmd.div_step) begin
         dividend_ff <= {dividend_ff[46:0], 1'b0};
         if (prem_sh >= 55'(den_ff)) begin
            prem_ff <= prem_sh - 55'(den_ff);
            quo_ff  <= {quo_ff[46:0], 1'b1};
         end else begin
            prem_ff <= prem_sh;
            quo_ff  <= {quo_ff[46:0], 1'b0};
         end
         dv_cnt_ff <= dv_cnt_ff + 6'd1;
      end
   end

   logic [31:0] score;
   always_comb begin
      if (out_of_range) score = '0;
      else if (quo_ff[47:32] != '0) score = '1;
      else score = quo_ff[31:0];
   end

   // sorted table: scan from bottom upwards, shifting lower entries down
   logic [31:0] tab_s_ff [MAX_KEPT];
   logic [15:0] tab_t_ff [MAX_KEPT];
   logic [CntW-1:0] held_ff;
   logic [CntW-1:0] pos_ff;     // candidate slot
   logic [31:0] new_s_ff;
   logic            above;
   logic [IdxW-1:0] src;
   assign src   = IdxW'(pos_ff - CntW'(1));
   assign above = (pos_ff != '0) && (tab_s_ff[src] < new_s_ff);

   always_ff @(posedge clock) begin
      if (cmd.scan_init) begin
         new_s_ff <= score;
         pos_ff   <= held_ff;
      end else if (cmd.scan_step) begin
         if (above) begin
            if (pos_ff < CntW'(MAX_KEPT)) begin
               tab_s_ff[IdxW'(pos_ff)] <= tab_s_ff[src];
               tab_t_ff[IdxW'(pos_ff)] <= tab_t_ff[src];
            end
            pos_ff <= pos_ff - CntW'(1);
         end
      end else if (cmd.insert) begin
         if (pos_ff < CntW'(MAX_KEPT)) begin
            tab_s_ff[IdxW'(pos_ff)] <= new_s_ff;
            tab_t_ff[IdxW'(pos_ff)] <= tag_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.frame_clear) held_ff <= '0;
      else if (cmd.insert && pos_ff < CntW'(MAX_KEPT) && held_ff < CntW'(MAX_KEPT))
         held_ff <= held_ff + CntW'(1);
   end

   // emit pointer
   logic [CntW-1:0] em_ff;
   always_ff @(posedge clock) begin
      if (cmd.emit_init) em_ff <= '0;
      else if (cmd.emit_step) em_ff <= em_ff + CntW'(1);
   end
   assign out_tag   = tab_t_ff[IdxW'(em_ff)];
   assign out_score = tab_s_ff[IdxW'(em_ff)];
   assign out_rank  = RankWidth'(em_ff);
   assign out_last  = (em_ff + CntW'(1) == held_ff);

   // status back to the controller
   always_comb begin
      status.sqrt_done = (sq_cnt_ff == 5'd26);
      status.div_done  = (dv_cnt_ff == 6'd48);
      status.scan_done = !above;
      status.emit_done = out_last;
   end
endmodule
`default_nettype wire

// ----- sv/plit_control.sv -----
`default_nettype none
module plit_control (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic                     req_last_light,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output plit_pkg::plit_cmd_type        cmd,
   input  wire plit_pkg::plit_status_type status
);
   import plit_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_SQ, S_SQRT_I, S_SQRT, S_DEN, S_DIV_I, S_DIV, S_SCAN_I, S_SCAN,
      S_INS, S_EMIT
   } state_type;

   state_type state_ff;
   logic [1:0] sq_cnt_ff;
   logic       last_ff;

   // state and registered flags
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         sq_cnt_ff <= '0;
         last_ff   <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: if (req_valid) begin
               state_ff  <= S_SQ;
               sq_cnt_ff <= '0;
               last_ff   <= req_last_light;
            end
            S_SQ: begin
               sq_cnt_ff <= sq_cnt_ff + 2'd1;
               if (sq_cnt_ff == 2'd3) state_ff <= S_SQRT_I;
            end
            S_SQRT_I: state_ff <= S_SQRT;
            S_SQRT:   if (status.sqrt_done) state_ff <= S_DEN;
            S_DEN:    state_ff <= S_DIV_I;
            S_DIV_I:  state_ff <= S_DIV;
            S_DIV:    if (status.div_done) state_ff <= S_SCAN_I;
            S_SCAN_I: state_ff <= S_SCAN;
            S_SCAN:   if (status.scan_done) state_ff <= S_INS;
            S_INS:    state_ff <= last_ff ? S_EMIT : S_IDLE;
            S_EMIT:   if (!rsp_stall && status.emit_done) state_ff <= S_IDLE;
            default:  state_ff <= S_IDLE;
         endcase
      end
   end

   always_comb begin
      cmd = '0;
      cmd.load        = (state_ff == S_IDLE) && req_valid;
      cmd.sq_step     = (state_ff == S_SQ);
      cmd.sqrt_init   = (state_ff == S_SQRT_I);
      cmd.sqrt_step   = (state_ff == S_SQRT) && !status.sqrt_done;
      cmd.den_calc    = (state_ff == S_DEN);
      cmd.div_init    = (state_ff == S_DIV_I);
      cmd.div_step    = (state_ff == S_DIV) && !status.div_done;
      cmd.scan_init   = (state_ff == S_SCAN_I);
      cmd.scan_step   = (state_ff == S_SCAN);
      cmd.insert      = (state_ff == S_INS);
      cmd.emit_init   = (state_ff == S_INS);
      cmd.emit_step   = (state_ff == S_EMIT) && !rsp_stall;
      cmd.frame_clear = (state_ff == S_EMIT) && !rsp_stall && status.emit_done;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_EMIT);

   // results only while emitting, never while taking a transaction
   a_excl: assert property (@(posedge clock) disable iff (reset) !(rsp_valid && !req_stall))
      else $error("result offered while input open");
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == S_SQ) else $error("load did not start work");
   a_emit_end: assert property (@(posedge clock) disable iff (reset)
      cmd.frame_clear |=> state_ff == S_IDLE) else $error("emit did not finish");
endmodule
`default_nettype wire

// ----- sv/point_light_importance_topk.sv -----
// channel  | valid     | stall     | payload
// req      | req_valid | req_stall | tag, position, range, intensity, last flag
// rsp      | rsp_valid | rsp_stall | tag, importance, rank, last flag
// csr      | csr_write | -         | csr_index, csr_data
// a light goes through accept, squaring, square root, denominator, division, table scan
// and insert, with set-up steps between; the scan shifts lower table entries down;
// req_stall stays high until idle again
// the last light is followed by one result per held entry, one per cycle unless stalled
// reset is synchronous and clears the controller, camera and fill count
`default_nettype none
module point_light_importance_topk #(
   parameter int MAX_KEPT = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_write,
   input  wire logic [1:0]         csr_index,
   input  wire logic [23:0]        csr_data,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [15:0]        req_light_tag,
   input  wire logic signed [23:0] req_pos_x,
   input  wire logic signed [23:0] req_pos_y,
   input  wire logic signed [23:0] req_pos_z,
   input  wire logic [23:0]        req_light_range,
   input  wire logic [15:0]        req_intensity,
   input  wire logic               req_last_light,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [15:0]             rsp_ranked_tag,
   output logic [31:0]             rsp_importance,
   output logic [5:0]              rsp_rank,
   output logic                    rsp_last_result
);
   import plit_pkg::*;

   plit_cmd_type    cmd;
   plit_status_type status;

   plit_control u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .req_last_light,
      .rsp_valid, .rsp_stall, .cmd, .status
   );

   plit_datapath #(.MAX_KEPT(MAX_KEPT)) u_dp (
      .clock, .reset, .cmd, .status, .csr_write, .csr_index, .csr_data,
      .req_light_tag, .req_pos_x, .req_pos_y, .req_pos_z, .req_light_range,
      .req_intensity, .out_tag(rsp_ranked_tag), .out_score(rsp_importance),
      .out_rank(rsp_rank), .out_last(rsp_last_result)
   );
endmodule
`default_nettype wire
